// ===== design/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg
// types and constants shared by the lru key-value cache modules
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic                      cmd;
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } lkv_req_t;

    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] read_value;
    } lkv_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_RESOLVE,
        ST_UPDATE
    } lkv_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic resolve;
        logic commit;
        logic cfg_we;
    } lkv_cmd_t;

endpackage

// ===== design/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value store kept in least-recently-used order
// ----------------------------------------------------------------------------
//  channel  handshake             word
//  req      req_valid/req_stall   lkv_req_t  {cmd, key, value}
//  rsp      rsp_valid/rsp_stall   lkv_rsp_t  {hit, read_value}
//  cfg      cfg_valid/cfg_ready   capacity, 5 bits
//
//  a request goes through capture, key compare, slot select with the value
//  ram read, then rank update and value write.
//  the rank update waits while a previous result word is still stalled.
//  reset clears valid marks, ranks and occupancy at once; capacity resets to 16.
//  a new request is taken while the last result word still waits.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  lkv_pkg::lkv_req_t         req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output lkv_pkg::lkv_rsp_t         rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_data
);
    import lkv_pkg::*;

    lkv_cmd_t cmd;

    lkv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    lkv_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_data (cfg_data),
        .rsp      (rsp)
    );

endmodule

// ===== design/lkv_ram.sv =====
// ----------------------------------------------------------------------------
// lkv_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lkv_ctrl.sv =====
// ----------------------------------------------------------------------------
// lkv_ctrl
// request sequencer and response valid for the lru key-value cache
// ----------------------------------------------------------------------------
module lkv_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    output lkv_pkg::lkv_cmd_t cmd
);
    import lkv_pkg::*;

    lkv_state_t state_reg;
    lkv_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       rsp_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        req_stall      = 1'b1;
        cfg_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall  = 1'b0;
                cfg_ready  = 1'b1;
                cmd.cfg_we = cfg_valid;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // hold until the result word has somewhere to go
                if (rsp_free)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== design/lkv_datapath.sv =====
// ----------------------------------------------------------------------------
// lkv_datapath
// entry keys, valid marks, recency ranks, value ram and result register
// ----------------------------------------------------------------------------
module lkv_datapath #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lkv_pkg::lkv_cmd_t           cmd,
    input  lkv_pkg::lkv_req_t           req,
    input  logic [lkv_pkg::CAP_W-1:0]   cfg_data,
    output lkv_pkg::lkv_rsp_t           rsp
);
    import lkv_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);

    lkv_req_t           req_reg;
    lkv_rsp_t           rsp_reg;
    logic [KEY_W-1:0]   key_reg   [MAX_ENTRIES];
    logic               valid_reg [MAX_ENTRIES];
    logic [IDX_W-1:0]   rank_reg  [MAX_ENTRIES];
    logic [IDX_W-1:0]   rank_next [MAX_ENTRIES];
    logic [OCC_W-1:0]   occ_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [MAX_ENTRIES-1:0] match_reg;
    logic [MAX_ENTRIES-1:0] victim_reg;
    logic [MAX_ENTRIES-1:0] sel_reg;
    logic [MAX_ENTRIES-1:0] sel_next;
    logic [IDX_W-1:0]   slot_reg;
    logic [IDX_W-1:0]   slot_next;
    logic [IDX_W-1:0]   r_reg;
    logic [IDX_W-1:0]   r_next;
    logic               hit_reg;
    logic               touch_reg;
    logic               touch_next;
    logic               new_reg;
    logic               new_next;
    logic               grow_reg;
    logic               grow_next;

    logic [OCC_W-1:0]   eff_cap;
    logic               hit;
    logic [IDX_W-1:0]   match_idx;
    logic [IDX_W-1:0]   match_rank;
    logic [IDX_W-1:0]   victim_idx;
    logic [IDX_W-1:0]   top_rank;
    logic [VALUE_W-1:0] ram_rdata;
    logic               ram_we;

    // a capacity of zero acts as one, above the entry count as the entry count
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = OCC_W'(1);
        end
        else if (32'(cap_reg) > MAX_ENTRIES)
        begin
            eff_cap = OCC_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = OCC_W'(cap_reg);
        end
    end

    assign top_rank = IDX_W'(occ_reg - OCC_W'(1));

    // keys and ranks are unique among valid entries, so match and victim are one-hot or zero
    always_comb
    begin
        match_idx  = '0;
        match_rank = '0;
        victim_idx = '0;
        for (int j = 0; j < MAX_ENTRIES; j++)
        begin
            if (match_reg[j])
            begin
                match_idx  = match_idx | IDX_W'(j);
                match_rank = match_rank | rank_reg[j];
            end
            if (victim_reg[j])
            begin
                victim_idx = victim_idx | IDX_W'(j);
            end
        end
    end

    assign hit = |match_reg;

    always_comb
    begin
        sel_next   = '0;
        slot_next  = '0;
        r_next     = '0;
        touch_next = 1'b0;
        new_next   = 1'b0;
        grow_next  = 1'b0;
        priority if (hit)
        begin
            sel_next   = match_reg;
            slot_next  = match_idx;
            r_next     = match_rank;
            touch_next = 1'b1;
        end
        else if (req_reg.cmd == CMD_PUT)
        begin
            touch_next = 1'b1;
            new_next   = 1'b1;
            if (occ_reg >= eff_cap)
            begin
                sel_next  = victim_reg;
                slot_next = victim_idx;
                r_next    = top_rank;
            end
            else
            begin
                // valid entries always fill the low slots in order
                for (int j = 0; j < MAX_ENTRIES; j++)
                begin
                    sel_next[j] = (occ_reg == OCC_W'(j));
                end
                slot_next = IDX_W'(occ_reg);
                r_next    = IDX_W'(occ_reg);
                grow_next = 1'b1;
            end
        end
        else
        begin
            // a get that misses leaves every entry alone
            touch_next = 1'b0;
        end
    end

    always_comb
    begin
        for (int j = 0; j < MAX_ENTRIES; j++)
        begin
            rank_next[j] = rank_reg[j];
            if (touch_reg)
            begin
                if (sel_reg[j])
                begin
                    rank_next[j] = '0;
                end
                else if (valid_reg[j] && (rank_reg[j] < r_reg))
                begin
                    rank_next[j] = rank_reg[j] + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            cap_reg <= CAP_RESET;
            for (int j = 0; j < MAX_ENTRIES; j++)
            begin
                valid_reg[j] <= 1'b0;
                rank_reg[j]  <= '0;
            end
        end
        else
        begin
            if (cmd.cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                if (grow_reg)
                begin
                    occ_reg <= occ_reg + OCC_W'(1);
                end
                for (int j = 0; j < MAX_ENTRIES; j++)
                begin
                    rank_reg[j] <= rank_next[j];
                    if (sel_reg[j] && new_reg)
                    begin
                        valid_reg[j] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.compare)
        begin
            for (int j = 0; j < MAX_ENTRIES; j++)
            begin
                match_reg[j]  <= valid_reg[j] && (key_reg[j] == req_reg.key);
                victim_reg[j] <= valid_reg[j] && (rank_reg[j] == top_rank);
            end
        end
        if (cmd.resolve)
        begin
            sel_reg   <= sel_next;
            slot_reg  <= slot_next;
            r_reg     <= r_next;
            hit_reg   <= hit;
            touch_reg <= touch_next;
            new_reg   <= new_next;
            grow_reg  <= grow_next;
        end
        if (cmd.commit)
        begin
            for (int j = 0; j < MAX_ENTRIES; j++)
            begin
                if (sel_reg[j] && new_reg)
                begin
                    key_reg[j] <= req_reg.key;
                end
            end
            rsp_reg.hit <= hit_reg;
            if ((req_reg.cmd == CMD_GET) && hit_reg)
            begin
                rsp_reg.read_value <= ram_rdata;
            end
            else
            begin
                rsp_reg.read_value <= '0;
            end
        end
    end

    assign ram_we = cmd.commit && (req_reg.cmd == CMD_PUT) && touch_reg;

    lkv_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (req_reg.value),
        .re    (cmd.resolve),
        .raddr (match_idx),
        .rdata (ram_rdata)
    );

    assign rsp = rsp_reg;

endmodule

// ===== design/lkv_checker.sv =====
// ----------------------------------------------------------------------------
// lkv_checker
// port-level checks for the lru key-value cache
// ----------------------------------------------------------------------------
module lkv_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_stall,
    input logic                      rsp_valid,
    input logic                      rsp_stall,
    input lkv_pkg::lkv_rsp_t         rsp,
    input logic                      cfg_valid,
    input logic                      cfg_ready
);
    import lkv_pkg::*;

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result word changed while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another is in flight");

    // a miss never carries a value
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.hit |-> rsp.read_value == '0)
        else $error("miss returned a nonzero value");

    // a new result only follows work in flight
    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result word with no request in flight");

    // configuration is only taken while no request is in flight
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !req_stall)
        else $error("configuration taken during a request");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
